FILE: design/acf_nle_pkg.sv
// shared types and constants of the acf noise level estimator
package acf_nle_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 32;
   localparam int FRACTION_BITS_DEFAULT = 8;
   localparam int DATA_W = 32;
   localparam int NOISE_W = 40;
   localparam int COUNT_W = 16;
   localparam int SUM_W = 56;
   localparam int SQSUM_W = 64;
   localparam int AVG_W = 10;
   localparam int UNIT_W = 64;
   localparam int ROOT_W = 32;
   localparam int BAND_W = 40;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_re;
      logic signed [DATA_W-1:0] sample_im;
      logic                     lag_zero;
      logic                     lag_bad;
      logic                     last_of_record;
   } req_type;

   typedef struct packed {
      logic [NOISE_W-1:0] noise_level;
      logic               fallback_used;
      logic [COUNT_W-1:0] lags_used;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_OPEN = 2'b00,
      KIND_DATA = 2'b01,
      KIND_SKIP = 2'b10
   } kind_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      kind_type                 kind;
      logic                     last;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] min_power;
      logic [AVG_W-1:0]  averages;
   } cfg_type;

   typedef enum logic {
      CSR_MIN_POWER = 1'b0,
      CSR_AVERAGES  = 1'b1
   } csr_index_type;

endpackage

FILE: design/acf_nle_sqrt.sv
// iterative integer square root, one result bit per cycle
module acf_nle_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [acf_nle_pkg::UNIT_W-1:0]      arg,
   output logic                                done,
   output logic [acf_nle_pkg::ROOT_W-1:0]      root
);

   localparam int W = acf_nle_pkg::UNIT_W;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] v_ff, v_in;
   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] trial;

   // next state of the digit recurrence
   always_comb begin
      trial = r_ff + b_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in = v_ff;
      r_in = r_ff;
      b_in = b_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in = arg;
         r_in = '0;
         b_in = W'(1) << (W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[acf_nle_pkg::ROOT_W-1:0];

endmodule

FILE: design/acf_nle_div.sv
// restoring divider, one quotient bit per cycle
module acf_nle_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [acf_nle_pkg::UNIT_W-1:0] num,
   input  logic [acf_nle_pkg::UNIT_W-1:0] den,
   output logic                           done,
   output logic [acf_nle_pkg::UNIT_W-1:0] quo
);

   localparam int W = acf_nle_pkg::UNIT_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   // shift, trial subtract, keep or restore
   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      diff = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo = quo_ff;

endmodule

FILE: design/acf_nle_front.sv
// front end: takes beats, classifies lags and queues them for the back end
module acf_nle_front #(
   parameter int SampleWidth = acf_nle_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  acf_nle_pkg::req_type  req_in,
   output logic                  item_valid,
   output acf_nle_pkg::item_type item_out,
   input  logic                  item_pop
);

   localparam int D = acf_nle_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(D);

   acf_nle_pkg::item_type entry_ff [D];
   acf_nle_pkg::item_type item_new;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff, fill_in;
   logic          push;
   logic          pop;
   logic signed [SampleWidth-1:0] re_low;
   logic signed [SampleWidth-1:0] im_low;

   // sign extend the low sample bits and classify the lag
   always_comb begin
      re_low = req_in.sample_re[SampleWidth-1:0];
      im_low = req_in.sample_im[SampleWidth-1:0];
      item_new.re = acf_nle_pkg::DATA_W'(re_low);
      item_new.im = acf_nle_pkg::DATA_W'(im_low);
      item_new.last = req_in.last_of_record;
      if (req_in.lag_zero) begin
         item_new.kind = acf_nle_pkg::KIND_OPEN;
      end else if (req_in.lag_bad) begin
         item_new.kind = acf_nle_pkg::KIND_SKIP;
      end else begin
         item_new.kind = acf_nle_pkg::KIND_DATA;
      end
   end

   // queue pointers
   always_comb begin
      busy = (fill_ff == (PW+1)'(D));
      push = start && !busy;
      pop = item_pop && (fill_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

   assign item_valid = (fill_ff != '0);
   assign item_out = entry_ff[rd_ptr_ff];

endmodule

FILE: design/acf_nle_back.sv
// back end: band setup, lag magnitude, statistics and the final estimate
module acf_nle_back #(
   parameter int FractionBits = acf_nle_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  acf_nle_pkg::cfg_type  cfg,
   input  logic                  item_valid,
   input  acf_nle_pkg::item_type item_in,
   output logic                  item_pop,
   output logic                  rsp_valid,
   output acf_nle_pkg::rsp_type  rsp_out
);

   localparam int W = acf_nle_pkg::UNIT_W;
   localparam int RW = acf_nle_pkg::ROOT_W;
   localparam int BW = acf_nle_pkg::BAND_W;
   localparam int CW = acf_nle_pkg::COUNT_W;
   localparam int SW = acf_nle_pkg::SUM_W;
   localparam int QW = acf_nle_pkg::SQSUM_W;
   localparam int DW = acf_nle_pkg::DATA_W;
   localparam int NW = acf_nle_pkg::NOISE_W;

   typedef enum logic [17:0] {
      ST_IDLE   = 18'b000000000000000001,
      ST_ROOT   = 18'b000000000000000010,
      ST_QUAL   = 18'b000000000000000100,
      ST_BAND   = 18'b000000000000001000,
      ST_SQRE   = 18'b000000000000010000,
      ST_SQIM   = 18'b000000000000100000,
      ST_MAGGO  = 18'b000000000001000000,
      ST_MAG    = 18'b000000000010000000,
      ST_CHECK  = 18'b000000000100000000,
      ST_ACC    = 18'b000000001000000000,
      ST_END    = 18'b000000010000000000,
      ST_FBDIV  = 18'b000000100000000000,
      ST_MEAN   = 18'b000001000000000000,
      ST_MSQ    = 18'b000010000000000000,
      ST_SQMEAN = 18'b000100000000000000,
      ST_VPOP   = 18'b001000000000000000,
      ST_ADD    = 18'b010000000000000000,
      ST_SIGMA  = 18'b100000000000000000
   } state_type;

   state_type state_ff, state_in;
   acf_nle_pkg::item_type cur_ff, cur_in;
   logic          res_phase_ff, res_phase_in;
   logic          range_ok_ff, range_ok_in;
   logic [BW-1:0] band_low_ff, band_low_in;
   logic [BW-1:0] band_high_ff, band_high_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [QW-1:0] sqsum_ff, sqsum_in;
   logic [RW-1:0] s_ff, s_in;
   logic [RW-1:0] mag_ff, mag_in;
   logic [RW-1:0] mean_ff, mean_in;
   logic [W-1:0]  sqre_ff, sqre_in;
   logic [W-1:0]  msq_ff, msq_in;
   logic [W-1:0]  vpop_ff, vpop_in;
   logic [W-1:0]  prod_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   acf_nle_pkg::rsp_type rsp_ff, rsp_in;

   logic [RW-1:0] mul_a, mul_b;
   logic          sq_start, sq_done;
   logic [W-1:0]  sq_arg;
   logic [RW-1:0] sq_root;
   logic          dv_start, dv_done;
   logic [W-1:0]  dv_num, dv_den, dv_quo;

   logic [acf_nle_pkg::AVG_W-1:0] avg_eff;
   logic [W-1:0]  avg_arg;
   logic [DW-1:0] ar, ai;
   logic [DW+2:0] p0_x5, mp_x8;
   logic [W-1:0]  p0, fl, two_fl;
   logic [SW:0]   sum_add;
   logic [QW:0]   sqsum_add;
   logic [W:0]    var_add;
   logic [W-1:0]  var_sat;
   logic [W-1:0]  vpop_now;
   logic [BW-1:0] mag_ext;

   // shared arithmetic units
   acf_nle_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .arg   (sq_arg),
      .done  (sq_done),
      .root  (sq_root)
   );

   acf_nle_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   // operand preparation
   always_comb begin
      avg_eff = (cfg.averages == '0) ? acf_nle_pkg::AVG_W'(1) : cfg.averages;
      avg_arg = W'(avg_eff) << (2 * FractionBits);
      ar = cur_ff.re[DW-1] ? (~cur_ff.re + DW'(1)) : cur_ff.re;
      ai = cur_ff.im[DW-1] ? (~cur_ff.im + DW'(1)) : cur_ff.im;
      p0_x5 = {3'b000, cur_ff.re} + {1'b0, cur_ff.re, 2'b00};
      mp_x8 = {cfg.min_power, 3'b000};
      p0 = W'(cur_ff.re);
      fl = dv_quo;
      two_fl = dv_quo << 1;
      sum_add = (SW+1)'(sum_ff) + (SW+1)'(mag_ff);
      sqsum_add = (QW+1)'(sqsum_ff) + (QW+1)'(prod_ff);
      var_add = (W+1)'(vpop_ff) + (W+1)'(dv_quo);
      var_sat = var_add[W] ? '1 : var_add[W-1:0];
      vpop_now = (msq_ff > prod_ff) ? msq_ff - prod_ff : '0;
      mag_ext = BW'(mag_ff);
   end

   // multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_SQRE: begin
            mul_a = ar;
            mul_b = ar;
         end
         ST_SQIM: begin
            mul_a = ai;
            mul_b = ai;
         end
         ST_CHECK: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         ST_SQMEAN: begin
            mul_a = mean_ff;
            mul_b = mean_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // registered product
   always_ff @(posedge clock) begin
      prod_ff <= W'(mul_a) * W'(mul_b);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      res_phase_in = res_phase_ff;
      range_ok_in = range_ok_ff;
      band_low_in = band_low_ff;
      band_high_in = band_high_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      sqsum_in = sqsum_ff;
      s_in = s_ff;
      mag_in = mag_ff;
      mean_in = mean_ff;
      sqre_in = sqre_ff;
      msq_in = msq_ff;
      vpop_in = vpop_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      item_pop = 1'b0;
      sq_start = 1'b0;
      sq_arg = avg_arg;
      dv_start = 1'b0;
      dv_num = '0;
      dv_den = W'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in = item_in;
               unique case (item_in.kind)
                  acf_nle_pkg::KIND_OPEN: begin
                     sq_start = 1'b1;
                     state_in = ST_ROOT;
                  end
                  acf_nle_pkg::KIND_DATA: begin
                     if (range_ok_ff && count_ff != '1) begin
                        state_in = ST_SQRE;
                     end else begin
                        state_in = ST_END;
                     end
                  end
                  default: begin
                     state_in = ST_END;
                  end
               endcase
            end
         end
         ST_ROOT: begin
            if (sq_done) begin
               s_in = sq_root;
               if (res_phase_ff) begin
                  dv_start = 1'b1;
                  dv_num = W'(mp_x8) << FractionBits;
                  dv_den = W'({sq_root, 2'b00}) + W'(sq_root);
                  state_in = ST_FBDIV;
               end else begin
                  state_in = ST_QUAL;
               end
            end
         end
         ST_QUAL: begin
            range_ok_in = 1'b0;
            if (cur_ff.re > 0 && p0_x5 <= mp_x8) begin
               dv_start = 1'b1;
               dv_num = p0 << FractionBits;
               dv_den = W'(s_ff);
               state_in = ST_BAND;
            end else begin
               state_in = ST_END;
            end
         end
         ST_BAND: begin
            if (dv_done) begin
               range_ok_in = 1'b1;
               band_high_in = BW'(p0 + fl);
               if (two_fl > p0) begin
                  band_low_in = BW'(p0 - fl);
               end else begin
                  band_low_in = BW'(p0 - two_fl);
               end
               state_in = ST_END;
            end
         end
         ST_SQRE: begin
            state_in = ST_SQIM;
         end
         ST_SQIM: begin
            sqre_in = prod_ff;
            state_in = ST_MAGGO;
         end
         ST_MAGGO: begin
            sq_start = 1'b1;
            sq_arg = sqre_ff + prod_ff;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            if (sq_done) begin
               mag_in = sq_root;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (mag_ext >= band_low_ff && mag_ext <= band_high_ff) begin
               state_in = ST_ACC;
            end else begin
               state_in = ST_END;
            end
         end
         ST_ACC: begin
            count_in = count_ff + CW'(1);
            sum_in = sum_add[SW] ? '1 : sum_add[SW-1:0];
            sqsum_in = sqsum_add[QW] ? '1 : sqsum_add[QW-1:0];
            state_in = ST_END;
         end
         ST_END: begin
            if (cur_ff.last) begin
               res_phase_in = 1'b1;
               if (count_ff < CW'(2)) begin
                  sq_start = 1'b1;
                  state_in = ST_ROOT;
               end else begin
                  dv_start = 1'b1;
                  dv_num = W'(sum_ff);
                  dv_den = W'(count_ff);
                  state_in = ST_MEAN;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FBDIV: begin
            if (dv_done) begin
               rsp_valid_in = 1'b1;
               rsp_in.noise_level = dv_quo[NW-1:0];
               rsp_in.fallback_used = 1'b1;
               rsp_in.lags_used = count_ff;
               state_in = ST_IDLE;
            end
         end
         ST_MEAN: begin
            if (dv_done) begin
               mean_in = dv_quo[RW-1:0];
               dv_start = 1'b1;
               dv_num = sqsum_ff;
               dv_den = W'(count_ff);
               state_in = ST_MSQ;
            end
         end
         ST_MSQ: begin
            if (dv_done) begin
               msq_in = dv_quo;
               state_in = ST_SQMEAN;
            end
         end
         ST_SQMEAN: begin
            state_in = ST_VPOP;
         end
         ST_VPOP: begin
            vpop_in = vpop_now;
            dv_start = 1'b1;
            dv_num = vpop_now;
            dv_den = W'(count_ff - CW'(1));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (dv_done) begin
               sq_start = 1'b1;
               sq_arg = var_sat;
               state_in = ST_SIGMA;
            end
         end
         ST_SIGMA: begin
            if (sq_done) begin
               rsp_valid_in = 1'b1;
               rsp_in.noise_level = (mean_ff > sq_root) ? NW'(mean_ff) : NW'(sq_root);
               rsp_in.fallback_used = 1'b0;
               rsp_in.lags_used = count_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // record done: back to a clean state
      if (rsp_valid_in) begin
         res_phase_in = 1'b0;
         range_ok_in = 1'b0;
         band_low_in = '0;
         band_high_in = '0;
         count_in = '0;
         sum_in = '0;
         sqsum_in = '0;
      end
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         res_phase_ff <= 1'b0;
         range_ok_ff <= 1'b0;
         band_low_ff <= '0;
         band_high_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         sqsum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         res_phase_ff <= res_phase_in;
         range_ok_ff <= range_ok_in;
         band_low_ff <= band_low_in;
         band_high_ff <= band_high_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         sqsum_ff <= sqsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      s_ff <= s_in;
      mag_ff <= mag_in;
      mean_ff <= mean_in;
      sqre_ff <= sqre_in;
      msq_ff <= msq_in;
      vpop_ff <= vpop_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out = rsp_ff;

endmodule

FILE: design/acf_noise_level_estimator_core.sv
// top level of the acf noise level estimator
//
//  channel   ports                       direction  beat taken when
//  request   start, busy, req_in         in         start high and busy low
//  response  rsp_valid, rsp_out          out        rsp_valid high, one cycle
//  csr       csr_valid, csr_ready,       in         csr_valid and csr_ready high
//            csr_index, csr_data
//
// a qualifying lag zero takes the root of averages plus one divide, one that does
// not qualify the root only, a data lag the 32-step square root of the magnitude;
// the end of a record takes three divides and a root, or a root and one divide
// when the fallback value is given. the divider has 64 steps, the root unit 32.
// reset is synchronous and clears control, counters and sums.
// a two-beat queue parts intake from the back end; busy rises when it is full.
// the receiver cannot stall; csr_ready is always high.
module acf_noise_level_estimator_core #(
   parameter int SampleWidth = acf_nle_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int FractionBits = acf_nle_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  acf_nle_pkg::req_type            req_in,
   output logic                            rsp_valid,
   output acf_nle_pkg::rsp_type            rsp_out,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  acf_nle_pkg::csr_index_type      csr_index,
   input  logic [acf_nle_pkg::DATA_W-1:0]  csr_data
);

   acf_nle_pkg::cfg_type  cfg_ff, cfg_in;
   acf_nle_pkg::item_type item;
   logic                  item_valid;
   logic                  item_pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            acf_nle_pkg::CSR_MIN_POWER: cfg_in.min_power = csr_data;
            acf_nle_pkg::CSR_AVERAGES:  cfg_in.averages = csr_data[acf_nle_pkg::AVG_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_power <= '0;
         cfg_ff.averages <= acf_nle_pkg::AVG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   acf_nle_front #(
      .SampleWidth (SampleWidth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_in     (req_in),
      .item_valid (item_valid),
      .item_out   (item),
      .item_pop   (item_pop)
   );

   acf_nle_back #(
      .FractionBits (FractionBits)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_in    (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_valid),
      .rsp_out    (rsp_out)
   );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the acf noise level estimator core
`timescale 1ns / 1ps

module tb_top;

   localparam int FB = acf_nle_pkg::FRACTION_BITS_DEFAULT;
   localparam int NW = acf_nle_pkg::NOISE_W;
   localparam int SETTLE_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [63:0] SUM_TOP = (64'h1 << acf_nle_pkg::SUM_W) - 1;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   acf_nle_pkg::req_type       req_in = '0;
   logic                       rsp_valid;
   acf_nle_pkg::rsp_type       rsp_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   acf_nle_pkg::csr_index_type csr_index = acf_nle_pkg::CSR_MIN_POWER;
   logic [31:0]                csr_data = '0;

   // predictor copy of configuration and range state
   logic [31:0] cfg_min_power;
   logic [9:0]  cfg_averages;
   bit          range_open;
   logic [63:0] band_lo, band_hi;
   logic [15:0] lag_count;
   logic [55:0] mag_sum;
   logic [63:0] sq_sum;

   acf_nle_pkg::rsp_type noise_expected[$];
   int      errors = 0;
   int      items_sent = 0;
   int      idle_cycles = 0;

   acf_noise_level_estimator_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_in(req_in),
      .rsp_valid(rsp_valid), .rsp_out(rsp_out), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] root_of_averages();
      logic [63:0] n;
      n = (cfg_averages == 0) ? 64'd1 : 64'(cfg_averages);
      return int_sqrt(n << (2 * FB));
   endfunction

   function automatic void clear_range_state();
      range_open = 0;
      band_lo = 0;
      band_hi = 0;
      lag_count = 0;
      mag_sum = 0;
      sq_sum = 0;
   endfunction

   // advance the predictor by one accepted lag, queue the estimate on record end
   function automatic void estimate_noise(acf_nle_pkg::req_type r);
      longint      re, im;
      logic [63:0] s, p0, fl, ar, ai, mag, sq, wide, n, mean, msq, m2, vpop, add, var_s;
      logic [63:0] sigma, limit;
      acf_nle_pkg::rsp_type e;
      re = r.sample_re;
      im = r.sample_im;
      s = root_of_averages();
      limit = 64'(cfg_min_power) * 8;
      if (r.lag_zero) begin
         range_open = 0;
         if (re > 0 && 64'(re) * 5 <= limit) begin
            p0 = 64'(re);
            fl = (p0 << FB) / s;
            band_lo = (2 * fl > p0) ? p0 + fl - 2 * fl : p0 - 2 * fl;
            band_hi = p0 + fl;
            range_open = 1;
         end
      end else if (range_open && !r.lag_bad && lag_count != 16'hFFFF) begin
         ar = 64'(re < 0 ? -re : re);
         ai = 64'(im < 0 ? -im : im);
         mag = int_sqrt(ar * ar + ai * ai);
         if (mag >= band_lo && mag <= band_hi) begin
            sq = mag * mag;
            lag_count++;
            wide = 64'(mag_sum) + mag;
            mag_sum = (wide > SUM_TOP) ? SUM_TOP[55:0] : wide[55:0];
            sq_sum = (sq_sum > ~64'h0 - sq) ? ~64'h0 : sq_sum + sq;
         end
      end
      if (!r.last_of_record) return;
      if (lag_count < 2) begin
         e.noise_level = NW'((limit << FB) / (5 * s));
         e.fallback_used = 1'b1;
      end else begin
         n = 64'(lag_count);
         mean = 64'(mag_sum) / n;
         msq = sq_sum / n;
         m2 = mean * mean;
         vpop = (msq > m2) ? msq - m2 : 0;
         add = vpop / (n - 1);
         var_s = (vpop > ~64'h0 - add) ? ~64'h0 : vpop + add;
         sigma = int_sqrt(var_s);
         e.noise_level = NW'(mean > sigma ? mean : sigma);
         e.fallback_used = 1'b0;
      end
      e.lags_used = lag_count;
      noise_expected.push_back(e);
      clear_range_state();
   endfunction

   function automatic acf_nle_pkg::req_type make_lag(logic [31:0] re, logic [31:0] im,
                                                     bit lz, bit bad, bit last);
      acf_nle_pkg::req_type r;
      r.sample_re = re;
      r.sample_im = im;
      r.lag_zero = lz;
      r.lag_bad = bad;
      r.last_of_record = last;
      return r;
   endfunction

   // result check against the oldest estimate
   always @(posedge clock) begin
      acf_nle_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (noise_expected.size() == 0) begin
            $error("unexpected result beat noise_level=%0d", rsp_out.noise_level);
            errors++;
         end else begin
            e = noise_expected.pop_front();
            if (rsp_out.noise_level !== e.noise_level) begin
               $error("noise_level expected %0d actual %0d", e.noise_level,
                      rsp_out.noise_level);
               errors++;
            end
            if (rsp_out.fallback_used !== e.fallback_used) begin
               $error("fallback_used expected %0d actual %0d", e.fallback_used,
                      rsp_out.fallback_used);
               errors++;
            end
            if (rsp_out.lags_used !== e.lags_used) begin
               $error("lags_used expected %0d actual %0d", e.lags_used, rsp_out.lags_used);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one lag beat; start stays high when the next lag follows directly
   task automatic send_lag(acf_nle_pkg::req_type r);
      int gap, pick;
      start <= 1'b1;
      req_in <= r;
      do @(posedge clock); while (busy);
      estimate_noise(r);
      items_sent++;
      pick = $urandom_range(99);
      gap = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(3, 1) : $urandom_range(60, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every estimate has come and the back end is quiet
   task automatic drain();
      start <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(acf_nle_pkg::csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == acf_nle_pkg::CSR_MIN_POWER) cfg_min_power = value;
      else cfg_averages = value[9:0];
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] min_power, logic [31:0] averages);
      drain();
      write_csr(acf_nle_pkg::CSR_MIN_POWER, min_power);
      write_csr(acf_nle_pkg::CSR_AVERAGES, averages);
   endtask

   // one record of random ranges, mostly lags inside the band
   task automatic send_record();
      int          n_ranges, n_lags, pick;
      bit          last;
      logic [63:0] limit, p0, t, span;
      logic [31:0] re, im;
      n_ranges = $urandom_range(3, 1);
      if ($urandom_range(9) == 0)
         send_lag(make_lag($urandom(), $urandom(), 0, $urandom_range(1), 0));
      for (int k = 0; k < n_ranges; k++) begin
         n_lags = ($urandom_range(19) == 0) ? $urandom_range(30, 10) : $urandom_range(6);
         limit = (64'(cfg_min_power) * 8) / 5;
         pick = $urandom_range(99);
         if (cfg_min_power == 0 || pick < 12) p0 = 64'($urandom());
         else if (pick < 18) p0 = (limit > POS_MAX) ? POS_MAX : limit;
         else if (pick < 22) p0 = limit + 1;
         else p0 = $urandom_range((limit > POS_MAX) ? POS_MAX : limit, 1);
         last = (k == n_ranges - 1) && (n_lags == 0);
         send_lag(make_lag(p0[31:0], $urandom(), 1, $urandom_range(9) == 0, last));
         for (int j = 1; j <= n_lags; j++) begin
            last = (k == n_ranges - 1) && (j == n_lags);
            pick = $urandom_range(99);
            if (range_open && pick < 75) begin
               span = band_hi - band_lo;
               if (pick < 8) t = band_lo;
               else if (pick < 16) t = band_hi;
               else t = band_lo + ((span > POS_MAX) ? 64'($urandom_range(32'h7FFF_FFFF))
                                                    : 64'($urandom_range(span[31:0])));
               if (t > POS_MAX) t = POS_MAX;
               re = $urandom_range(1) ? t[31:0] : -t[31:0];
               im = $urandom_range(1) ? 32'd0 : 32'($signed($urandom_range(6)) - 3);
            end else begin
               re = $urandom();
               im = $urandom();
            end
            send_lag(make_lag(re, im, 0, $urandom_range(9) == 0, last));
         end
      end
   endtask

   // extremes of the fields and each special case
   task automatic test_directed();
      configure(32'd256000, 32'd4);
      // stray lag before any lag zero, then a range at the exact limit with bad flag
      send_lag(make_lag(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
      send_lag(make_lag(32'd409600, 32'd0, 1, 1, 0));
      send_lag(make_lag(32'd409600, 32'd0, 0, 0, 0));
      send_lag(make_lag(-32'd409600, 32'd0, 0, 0, 0));
      send_lag(make_lag(32'd300000, 32'd5, 0, 1, 0));
      send_lag(make_lag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
      send_lag(make_lag(32'h8000_0000, 32'h8000_0000, 0, 0, 1));
      // just over the limit, then zero power closing on lag zero
      send_lag(make_lag(32'd409601, 32'd0, 1, 0, 0));
      send_lag(make_lag(32'd409601, 32'd0, 0, 0, 1));
      send_lag(make_lag(32'd0, 32'hFFFF_FFFF, 1, 0, 1));
      // negative power, then one accepted lag only
      send_lag(make_lag(32'h8000_0000, 32'd0, 1, 0, 0));
      send_lag(make_lag(32'd1000, 32'd0, 0, 0, 0));
      send_lag(make_lag(32'd1000, 32'd0, 1, 0, 0));
      send_lag(make_lag(32'd1000, 32'd0, 0, 0, 1));
      // averages zero and full registers
      configure(32'hFFFF_FFFF, 32'd0);
      send_lag(make_lag(32'h7FFF_FFFF, 32'd0, 1, 0, 0));
      send_lag(make_lag(32'h7FFF_FFFF, 32'd0, 0, 0, 0));
      send_lag(make_lag(32'h7FFF_0000, 32'h0000_FFFF, 0, 0, 1));
      configure(32'hFFFF_FFFF, 32'd1023);
      send_lag(make_lag(32'h4000_0000, 32'd0, 1, 0, 0));
      send_lag(make_lag(32'h4000_0000, 32'd0, 0, 0, 0));
      send_lag(make_lag(32'h3FFF_FFFF, 32'd0, 0, 0, 0));
      send_lag(make_lag(32'h4000_0001, 32'd0, 0, 0, 1));
      configure(32'd0, 32'd1);
      send_lag(make_lag(32'd1, 32'd0, 1, 0, 0));
      send_lag(make_lag(32'd1, 32'd0, 0, 0, 1));
   endtask

   task automatic test_random_records();
      logic [31:0] mp, avg;
      int          phase_end;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin mp = 32'h0000_0100; avg = 1; end
            1: begin mp = 32'hFFFF_FFFF; avg = 1023; end
            2: begin mp = 32'd0; avg = $urandom_range(1023, 1); end
            3: begin mp = $urandom(); avg = 1; end
            default: begin
               mp = $urandom_range(1, 0) ? $urandom() : $urandom_range(32'h0010_0000, 1);
               avg = $urandom_range(1023, 1);
            end
         endcase
         configure(mp, avg);
         phase_end = items_sent + 210;
         while (items_sent < phase_end) send_record();
      end
   endtask

   // sender holds off until every estimate is back, then resumes
   task automatic test_pause_until_drained();
      configure(32'h0004_0000, 32'd16);
      repeat (5) send_record();
      drain();
      repeat (10) send_record();
   endtask

   initial begin
      cfg_min_power = 0;
      cfg_averages = 1;
      clear_range_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pause_until_drained();
      test_random_records();
      drain();
      if (errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

endmodule
